// ----- hdl/polygon_mass_properties_unit_assert.svh -----
// Assertion macros shared by the polygon mass properties RTL.
`ifndef POLYGON_MASS_PROPERTIES_UNIT_ASSERT_SVH
`define POLYGON_MASS_PROPERTIES_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define PMP_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("pmp check failed");
`define PMP_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pmp check failed");
`else
`define PMP_ASSERT(lbl, cond)
`define PMP_ASSERT_IMPL(lbl, ante, cons)
`endif
`endif

// ----- hdl/pmp_pkg.sv -----
// Shared types and constants for the polygon mass properties unit.
`timescale 1ns / 1ps
package pmp_pkg;

    localparam int COORD_W      = 16;
    localparam int MAX_VERTICES = 64;
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int QUEUE_DEPTH  = 2;
    localparam int DIV_STEPS    = 80;

    typedef struct packed {
        logic signed [COORD_W-1:0] vertex_x;
        logic signed [COORD_W-1:0] vertex_y;
        logic        [15:0]        body_mass;
        logic                      last_vertex;
    } pmp_in_t;

    typedef struct packed {
        logic signed [36:0] area;
        logic signed [15:0] centroid_x;
        logic signed [15:0] centroid_y;
        logic        [47:0] inertia;
        logic               zero_area;
        logic               vertex_overflow;
        logic               inertia_saturated;
    } pmp_out_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] ax;
        logic signed [COORD_W-1:0] ay;
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] by;
    } pmp_edge_t;

    // One queued job: an optional vertex edge and an optional closing edge, plus closing information.
    typedef struct packed {
        logic        e1_valid;
        pmp_edge_t   e1;
        logic        close;
        logic        e2_valid;
        pmp_edge_t   e2;
        logic [15:0] mass;
        logic        overflow;
    } pmp_job_t;

endpackage

// ----- hdl/polygon_mass_properties_unit.sv -----
// Each queued vertex edge passes the back end in turn; a closing vertex adds its closing edge,
// then the mass product and the 80-step shared divide loop (skipped when zero area).
// The vertex rate is set by the four-step edge sequence of the back end; polygon closure
// is set by the one-bit-per-cycle restoring dividers.
// Reset (rst_n, asynchronous, active low) clears vertex tracking, queue, sums and
// the result register; no clearing pass is needed.
`timescale 1ns / 1ps
module polygon_mass_properties_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              vertex_valid,
    output logic              vertex_ready,
    input  pmp_pkg::pmp_in_t  vertex,
    output logic              result_valid,
    input  logic              result_ready,
    output pmp_pkg::pmp_out_t result
);
    import pmp_pkg::*;

    // Front to queue transaction
    logic     push_valid;
    logic     push_ready;
    pmp_job_t push_job;

    // Queue to back end transaction
    logic     pop_valid;
    logic     pop_ready;
    pmp_job_t pop_job;

    // Classify vertices: hold first/previous vertex, drop extras, build edge jobs.
    pmp_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .vertex_valid (vertex_valid),
        .vertex_ready (vertex_ready),
        .vertex       (vertex),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_job     (push_job)
    );

    // Decouple the front from the slow closing divides.
    pmp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    // Accumulate edge sums, divide on closure, hold the result until taken.
    pmp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_job      (pop_job),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

// ----- hdl/pmp_front.sv -----
// Front end: tracks first/previous vertex and turns vertices into edge jobs.
`timescale 1ns / 1ps
`include "polygon_mass_properties_unit_assert.svh"
module pmp_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              vertex_valid,
    output logic              vertex_ready,
    input  pmp_pkg::pmp_in_t  vertex,
    output logic              push_valid,
    input  logic              push_ready,
    output pmp_pkg::pmp_job_t push_job
);
    import pmp_pkg::*;

    logic signed [COORD_W-1:0] first_x_reg, first_y_reg, prev_x_reg, prev_y_reg;
    logic [CNT_W-1:0]          count_reg;
    logic                      ovf_reg;

    logic                      take;
    logic                      is_first;
    logic signed [COORD_W-1:0] new_x, new_y, new_fx, new_fy;
    logic [CNT_W-1:0]          count_next;
    logic                      accept;

    always_comb
    begin
        take       = count_reg < CNT_W'(MAX_VERTICES);
        is_first   = count_reg == '0;
        new_x      = take ? vertex.vertex_x : prev_x_reg;
        new_y      = take ? vertex.vertex_y : prev_y_reg;
        new_fx     = (take && is_first) ? vertex.vertex_x : first_x_reg;
        new_fy     = (take && is_first) ? vertex.vertex_y : first_y_reg;
        count_next = take ? count_reg + CNT_W'(1) : count_reg;

        push_job.e1_valid = take && !is_first;
        push_job.e1.ax    = prev_x_reg;
        push_job.e1.ay    = prev_y_reg;
        push_job.e1.bx    = vertex.vertex_x;
        push_job.e1.by    = vertex.vertex_y;
        push_job.close    = vertex.last_vertex;
        push_job.e2_valid = vertex.last_vertex && (count_next != '0);
        push_job.e2.ax    = new_x;
        push_job.e2.ay    = new_y;
        push_job.e2.bx    = new_fx;
        push_job.e2.by    = new_fy;
        push_job.mass     = vertex.body_mass;
        push_job.overflow = ovf_reg | !take;
    end

    assign vertex_ready = push_ready;
    assign push_valid   = vertex_valid && (push_job.e1_valid || vertex.last_vertex);
    assign accept       = vertex_valid && vertex_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_x_reg <= '0;
            first_y_reg <= '0;
            prev_x_reg  <= '0;
            prev_y_reg  <= '0;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
        end
        else if (accept)
        begin
            if (vertex.last_vertex)
            begin
                first_x_reg <= '0;
                first_y_reg <= '0;
                prev_x_reg  <= '0;
                prev_y_reg  <= '0;
                count_reg   <= '0;
                ovf_reg     <= 1'b0;
            end
            else
            begin
                first_x_reg <= new_fx;
                first_y_reg <= new_fy;
                prev_x_reg  <= new_x;
                prev_y_reg  <= new_y;
                count_reg   <= count_next;
                ovf_reg     <= ovf_reg | !take;
            end
        end
    end

    `PMP_ASSERT(a_count_bound, count_reg <= CNT_W'(MAX_VERTICES))
    `PMP_ASSERT_IMPL(a_first_no_ovf, count_reg == '0, !ovf_reg)

endmodule

// ----- hdl/pmp_queue.sv -----
// Short job queue between the front end and the arithmetic back end.
`timescale 1ns / 1ps
`include "polygon_mass_properties_unit_assert.svh"
module pmp_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  pmp_pkg::pmp_job_t push_job,
    output logic              pop_valid,
    input  logic              pop_ready,
    output pmp_pkg::pmp_job_t pop_job
);
    import pmp_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

    pmp_job_t            mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CNT_QW-1:0]   count_reg;
    logic                do_push, do_pop;

    assign push_ready = count_reg != CNT_QW'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_job    = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + PTR_W'(1);
            end
            unique case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + CNT_QW'(1);
                2'b01:   count_reg <= count_reg - CNT_QW'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

    `PMP_ASSERT(a_queue_bound, count_reg <= CNT_QW'(QUEUE_DEPTH))

endmodule

// ----- hdl/pmp_back.sv -----
// Back end: edge accumulation, closing divisions and the result register.
`timescale 1ns / 1ps
`include "polygon_mass_properties_unit_assert.svh"
module pmp_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pop_valid,
    output logic              pop_ready,
    input  pmp_pkg::pmp_job_t pop_job,
    output logic              result_valid,
    input  logic              result_ready,
    output pmp_pkg::pmp_out_t result
);
    import pmp_pkg::*;

    localparam int STEP_W = $clog2(DIV_STEPS);

    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL, ST_SUM, ST_PROD, ST_ACC, ST_MASS, ST_PREP, ST_DIV, ST_DONE
    } state_t;

    state_t              state_reg;
    pmp_job_t            job_reg;
    logic                edge_sel_reg;
    logic [STEP_W-1:0]   step_reg;
    logic                out_valid_reg;
    pmp_out_t            result_reg;

    // accumulators
    logic signed [38:0]  cross_sum_reg;
    logic signed [54:0]  mx_sum_reg, my_sum_reg;
    logic [63:0]         in_sum_reg;
    logic [37:0]         abs_sum_reg;
    logic                isat_reg;

    // edge datapath
    logic signed [31:0]  p_ab_reg, p_ba_reg, p_axx_reg, p_ayy_reg;
    logic signed [31:0]  p_bxx_reg, p_byy_reg, p_axbx_reg, p_ayby_reg;
    logic signed [16:0]  sx_reg, sy_reg;
    logic signed [32:0]  c_reg;
    logic [32:0]         d_reg;
    logic signed [49:0]  mx_prod_reg, my_prod_reg;
    logic [63:0]         term_reg;
    logic [31:0]         cmag_reg;

    // closing datapath
    logic [47:0]         plo_reg, phi_reg;
    logic signed [36:0]  area_reg;
    logic                zero_reg;
    logic [79:0]         num_i_reg, num_x_reg, num_y_reg;
    logic [48:0]         den_i_reg;
    logic [49:0]         rem_i_reg;
    logic [47:0]         q_i_reg;
    logic                ovf_i_reg;
    logic [40:0]         den_c_reg;
    logic [41:0]         rem_x_reg, rem_y_reg;
    logic [16:0]         q_x_reg, q_y_reg;
    logic                ovf_x_reg, ovf_y_reg, neg_x_reg, neg_y_reg;

    pmp_edge_t           cur_edge;
    logic signed [34:0]  d_sum;
    logic signed [32:0]  c_sum;
    logic [31:0]         cmag;
    logic [64:0]         term_full;
    logic [64:0]         in_add;
    logic [38:0]         cs_mag;
    logic [37:0]         am;
    logic signed [36:0]  area_calc;
    logic signed [40:0]  c3;
    logic [49:0]         sh_i;
    logic [41:0]         sh_x, sh_y;
    logic                ge_i, ge_x, ge_y;
    pmp_out_t            res_calc;
    logic                can_write;

    function automatic logic signed [15:0] sat_centroid(input logic [16:0] q,
                                                         input logic ovf,
                                                         input logic neg);
        logic signed [15:0] r;
        if (neg)
        begin
            r = (ovf || q > 17'd32768) ? -16'sd32768 : 16'(-q);
        end
        else
        begin
            r = (ovf || q > 17'd32767) ? 16'sd32767 : 16'(q);
        end
        return r;
    endfunction

    always_comb
    begin
        cur_edge  = edge_sel_reg ? job_reg.e2 : job_reg.e1;
        c_sum     = 33'(p_ab_reg) - 33'(p_ba_reg);
        d_sum     = 35'(p_axx_reg) + 35'(p_ayy_reg) + 35'(p_bxx_reg)
                  + 35'(p_byy_reg) + 35'(p_axbx_reg) + 35'(p_ayby_reg);
        cmag      = c_sum[32] ? 32'(-c_sum) : 32'(c_sum);
        term_full = cmag_reg * d_reg;
        in_add    = {1'b0, in_sum_reg} + {1'b0, term_reg};

        cs_mag    = cross_sum_reg[38] ? 39'(-cross_sum_reg) : 39'(cross_sum_reg);
        am        = cs_mag[38:1];
        if (cross_sum_reg[38])
        begin
            area_calc = (am > 38'h1000000000) ? 37'sh1000000000 : 37'(-am);
        end
        else
        begin
            area_calc = (am > 38'h0FFFFFFFFF) ? 37'sh0FFFFFFFFF : 37'(am);
        end
        c3        = 41'(cross_sum_reg) + (41'(cross_sum_reg) <<< 1);

        sh_i = {rem_i_reg[48:0], num_i_reg[79]};
        sh_x = {rem_x_reg[40:0], num_x_reg[79]};
        sh_y = {rem_y_reg[40:0], num_y_reg[79]};
        ge_i = sh_i >= {1'b0, den_i_reg};
        ge_x = sh_x >= {1'b0, den_c_reg};
        ge_y = sh_y >= {1'b0, den_c_reg};

        res_calc.area              = area_reg;
        res_calc.zero_area         = zero_reg;
        res_calc.vertex_overflow   = job_reg.overflow;
        if (zero_reg)
        begin
            res_calc.centroid_x        = '0;
            res_calc.centroid_y        = '0;
            res_calc.inertia           = '0;
            res_calc.inertia_saturated = isat_reg;
        end
        else
        begin
            res_calc.centroid_x        = sat_centroid(q_x_reg, ovf_x_reg, neg_x_reg);
            res_calc.centroid_y        = sat_centroid(q_y_reg, ovf_y_reg, neg_y_reg);
            res_calc.inertia           = ovf_i_reg ? '1 : q_i_reg;
            res_calc.inertia_saturated = isat_reg | ovf_i_reg;
        end
        can_write = !out_valid_reg || result_ready;
    end

    assign pop_ready    = state_reg == ST_IDLE;
    assign result_valid = out_valid_reg;
    assign result       = result_reg;

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_MUL:
            begin
                p_ab_reg   <= cur_edge.ax * cur_edge.by;
                p_ba_reg   <= cur_edge.bx * cur_edge.ay;
                p_axx_reg  <= cur_edge.ax * cur_edge.ax;
                p_ayy_reg  <= cur_edge.ay * cur_edge.ay;
                p_bxx_reg  <= cur_edge.bx * cur_edge.bx;
                p_byy_reg  <= cur_edge.by * cur_edge.by;
                p_axbx_reg <= cur_edge.ax * cur_edge.bx;
                p_ayby_reg <= cur_edge.ay * cur_edge.by;
                sx_reg     <= 17'(cur_edge.ax) + 17'(cur_edge.bx);
                sy_reg     <= 17'(cur_edge.ay) + 17'(cur_edge.by);
            end
            ST_SUM:
            begin
                c_reg    <= c_sum;
                d_reg    <= d_sum[32:0];
                cmag_reg <= cmag;
            end
            ST_PROD:
            begin
                mx_prod_reg <= sx_reg * c_reg;
                my_prod_reg <= sy_reg * c_reg;
                term_reg    <= term_full[63:0];
            end
            ST_MASS:
            begin
                plo_reg  <= job_reg.mass * in_sum_reg[31:0];
                phi_reg  <= job_reg.mass * in_sum_reg[63:32];
                area_reg <= area_calc;
                zero_reg <= (area_calc == '0) || (abs_sum_reg == '0);
            end
            ST_PREP:
            begin
                num_i_reg <= {phi_reg, 32'b0} + 80'(plo_reg);
                den_i_reg <= (49'(abs_sum_reg) << 10) + (49'(abs_sum_reg) << 9);
                rem_i_reg <= '0;
                q_i_reg   <= '0;
                ovf_i_reg <= 1'b0;
                num_x_reg <= 80'(mx_sum_reg[54] ? 55'(-mx_sum_reg) : 55'(mx_sum_reg));
                num_y_reg <= 80'(my_sum_reg[54] ? 55'(-my_sum_reg) : 55'(my_sum_reg));
                den_c_reg <= c3[40] ? 41'(-c3) : 41'(c3);
                rem_x_reg <= '0;
                rem_y_reg <= '0;
                q_x_reg   <= '0;
                q_y_reg   <= '0;
                ovf_x_reg <= 1'b0;
                ovf_y_reg <= 1'b0;
                neg_x_reg <= mx_sum_reg[54] ^ cross_sum_reg[38];
                neg_y_reg <= my_sum_reg[54] ^ cross_sum_reg[38];
            end
            ST_DIV:
            begin
                num_i_reg <= num_i_reg << 1;
                num_x_reg <= num_x_reg << 1;
                num_y_reg <= num_y_reg << 1;
                rem_i_reg <= ge_i ? sh_i - {1'b0, den_i_reg} : sh_i;
                rem_x_reg <= ge_x ? sh_x - {1'b0, den_c_reg} : sh_x;
                rem_y_reg <= ge_y ? sh_y - {1'b0, den_c_reg} : sh_y;
                q_i_reg   <= {q_i_reg[46:0], ge_i};
                q_x_reg   <= {q_x_reg[15:0], ge_x};
                q_y_reg   <= {q_y_reg[15:0], ge_y};
                ovf_i_reg <= ovf_i_reg | q_i_reg[47];
                ovf_x_reg <= ovf_x_reg | q_x_reg[16];
                ovf_y_reg <= ovf_y_reg | q_y_reg[16];
            end
            default:
            begin
            end
        endcase
    end

    // sequencer, accumulators and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            job_reg       <= '0;
            edge_sel_reg  <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            result_reg    <= '0;
            cross_sum_reg <= '0;
            mx_sum_reg    <= '0;
            my_sum_reg    <= '0;
            in_sum_reg    <= '0;
            abs_sum_reg   <= '0;
            isat_reg      <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && result_ready && !(state_reg == ST_DONE && can_write))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (pop_valid)
                    begin
                        job_reg <= pop_job;
                        if (pop_job.e1_valid)
                        begin
                            edge_sel_reg <= 1'b0;
                            state_reg    <= ST_MUL;
                        end
                        else if (pop_job.e2_valid)
                        begin
                            edge_sel_reg <= 1'b1;
                            state_reg    <= ST_MUL;
                        end
                        else if (pop_job.close)
                        begin
                            state_reg <= ST_MASS;
                        end
                    end
                end
                ST_MUL:  state_reg <= ST_SUM;
                ST_SUM:  state_reg <= ST_PROD;
                ST_PROD: state_reg <= ST_ACC;
                ST_ACC:
                begin
                    cross_sum_reg <= cross_sum_reg + 39'(c_reg);
                    mx_sum_reg    <= mx_sum_reg + 55'(mx_prod_reg);
                    my_sum_reg    <= my_sum_reg + 55'(my_prod_reg);
                    abs_sum_reg   <= abs_sum_reg + 38'(cmag_reg);
                    if (in_add[64])
                    begin
                        in_sum_reg <= '1;
                        isat_reg   <= 1'b1;
                    end
                    else
                    begin
                        in_sum_reg <= in_add[63:0];
                    end
                    priority if (edge_sel_reg)
                    begin
                        state_reg <= ST_MASS;
                    end
                    else if (job_reg.e2_valid)
                    begin
                        edge_sel_reg <= 1'b1;
                        state_reg    <= ST_MUL;
                    end
                    else if (job_reg.close)
                    begin
                        state_reg <= ST_MASS;
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_MASS: state_reg <= ST_PREP;
                ST_PREP:
                begin
                    step_reg  <= '0;
                    state_reg <= zero_reg ? ST_DONE : ST_DIV;
                end
                ST_DIV:
                begin
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == STEP_W'(DIV_STEPS - 1))
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (can_write)
                    begin
                        result_reg    <= res_calc;
                        out_valid_reg <= 1'b1;
                        cross_sum_reg <= '0;
                        mx_sum_reg    <= '0;
                        my_sum_reg    <= '0;
                        in_sum_reg    <= '0;
                        abs_sum_reg   <= '0;
                        isat_reg      <= 1'b0;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    `PMP_ASSERT_IMPL(a_div_den_nonzero, state_reg == ST_DIV,
                     den_i_reg != '0 && den_c_reg != '0)
    `PMP_ASSERT_IMPL(a_sat_sticks, isat_reg && state_reg != ST_DONE, in_sum_reg == '1)

endmodule
